[src/pfcs_pkg.sv]
package pfcs_pkg;

    // Default and upper bound for the number of CPUs sharing the PLL.
    localparam int CPU_COUNT_DEFAULT = 2;
    localparam int CPU_COUNT_MAX     = 8;

    // Field widths.
    localparam int INDEX_W   = 3;
    localparam int TICKS_W   = 16;
    localparam int MASK_W    = 2;
    localparam int WORD_W    = 32;
    localparam int KHZ_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [INDEX_W-1:0] MAX_INDEX = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [TICKS_W-1:0] HOLD_TICKS_RST   = 16'd2;
    localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 16'd50;
    localparam logic [INDEX_W-1:0] BOOT_INDEX_RST   = 3'd5;
    localparam logic [MASK_W-1:0]  ONLINE_MASK_RST  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_INDEX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK  = 3'd3;

    // Item kinds.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Bit ORed into the second control word while the PLL is bypassed.
    localparam int BYPASS_BIT = 15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HOLD,
        PH_SETTLE,
        PH_LOCK
    } phase_t;

    typedef struct packed {
        logic                  change_done;
        logic                  busy_res;
        logic [KHZ_W-1:0]      current_khz;
        logic [INDEX_W-1:0]    current_index;
        logic [WORD_W-1:0]     pll_ctl1_word;
        logic [WORD_W-1:0]     pll_ctl_word;
        logic                  pll_reset;
        logic                  pll_bypass;
        logic                  cpu_bypass;
    } result_t;

    function automatic logic [INDEX_W-1:0] sat_index(input logic [INDEX_W-1:0] v);
        sat_index = (v > MAX_INDEX) ? MAX_INDEX : v;
    endfunction

    function automatic logic [WORD_W-1:0] ctl_word(input logic [INDEX_W-1:0] idx);
        unique case (idx)
            3'd0:    ctl_word = 32'h8D48A005;
            3'd1:    ctl_word = 32'h8D48A005;
            3'd2:    ctl_word = 32'h9948B005;
            3'd3:    ctl_word = 32'h8D48A005;
            3'd4:    ctl_word = 32'h9548A805;
            default: ctl_word = 32'h9948B005;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] ctl1_word(input logic [INDEX_W-1:0] idx);
        unique case (idx)
            3'd0:    ctl1_word = 32'h0108342A;
            3'd1:    ctl1_word = 32'h010832AA;
            3'd2:    ctl1_word = 32'h010832AD;
            3'd3:    ctl1_word = 32'h0108312A;
            3'd4:    ctl1_word = 32'h0108312C;
            default: ctl1_word = 32'h0108312D;
        endcase
    endfunction

    function automatic logic [KHZ_W-1:0] index_khz(input logic [INDEX_W-1:0] idx);
        unique case (idx)
            3'd0:    index_khz = 21'd200000;
            3'd1:    index_khz = 21'd400000;
            3'd2:    index_khz = 21'd600000;
            3'd3:    index_khz = 21'd800000;
            3'd4:    index_khz = 21'd1000000;
            default: index_khz = 21'd1200000;
        endcase
    endfunction

endpackage

[src/pfcs_core.sv]
module pfcs_core #(
    parameter int CPU_COUNT = pfcs_pkg::CPU_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_accept,
    input  logic                              item_cmd,
    input  logic                              item_cpu_id,
    input  logic [pfcs_pkg::INDEX_W-1:0]      item_freq_index,
    input  logic                              item_pll_locked,
    input  logic                              cfg_write,
    input  logic [pfcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pfcs_pkg::result_t                 result
);

    logic [pfcs_pkg::TICKS_W-1:0] hold_ticks_reg, hold_ticks_next;
    logic [pfcs_pkg::TICKS_W-1:0] settle_ticks_reg, settle_ticks_next;
    logic [pfcs_pkg::INDEX_W-1:0] boot_index_reg, boot_index_next;
    logic [pfcs_pkg::MASK_W-1:0]  online_mask_reg, online_mask_next;
    logic [pfcs_pkg::INDEX_W-1:0] target_reg [CPU_COUNT];
    logic [pfcs_pkg::INDEX_W-1:0] target_next [CPU_COUNT];
    pfcs_pkg::phase_t             phase_reg, phase_next;
    logic [pfcs_pkg::TICKS_W-1:0] timer_reg, timer_next;
    logic [pfcs_pkg::INDEX_W-1:0] running_reg, running_next;
    logic [pfcs_pkg::INDEX_W-1:0] applying_reg, applying_next;

    logic [pfcs_pkg::CPU_COUNT_MAX-1:0] online_wide;
    logic [pfcs_pkg::INDEX_W-1:0]       fidx;
    logic [pfcs_pkg::INDEX_W-1:0]       want;
    logic [pfcs_pkg::INDEX_W-1:0]       widx;
    logic                               evaluate;
    logic                               started;
    logic                               done;
    logic                               busy;

    assign online_wide = {{(pfcs_pkg::CPU_COUNT_MAX - pfcs_pkg::MASK_W){1'b0}},
                          online_mask_reg};
    assign fidx = pfcs_pkg::sat_index(item_freq_index);

    always_comb
    begin
        hold_ticks_next   = hold_ticks_reg;
        settle_ticks_next = settle_ticks_reg;
        boot_index_next   = boot_index_reg;
        online_mask_next  = online_mask_reg;
        target_next       = target_reg;
        phase_next        = phase_reg;
        timer_next        = timer_reg;
        running_next      = running_reg;
        applying_next     = applying_reg;
        evaluate          = 1'b0;
        started           = 1'b0;
        done              = 1'b0;

        if (item_accept)
        begin
            if (item_cmd == pfcs_pkg::CMD_REQUEST)
            begin
                for (int i = 0; i < CPU_COUNT; i++)
                begin
                    if (int'(item_cpu_id) == i)
                    begin
                        target_next[i] = fidx;
                    end
                end
                evaluate = (phase_reg == pfcs_pkg::PH_IDLE);
            end
            else
            begin
                unique case (phase_reg)
                    pfcs_pkg::PH_HOLD:
                    begin
                        if (timer_reg == '0)
                        begin
                            phase_next = pfcs_pkg::PH_SETTLE;
                            timer_next = settle_ticks_reg;
                        end
                        else
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                    end
                    pfcs_pkg::PH_SETTLE:
                    begin
                        if (timer_reg == '0)
                        begin
                            phase_next = pfcs_pkg::PH_LOCK;
                        end
                        else
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                    end
                    pfcs_pkg::PH_LOCK:
                    begin
                        if (item_pll_locked)
                        begin
                            running_next = applying_reg;
                            phase_next   = pfcs_pkg::PH_IDLE;
                            timer_next   = '0;
                            done         = 1'b1;
                            evaluate     = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Highest target among the online CPUs, after this item's update.
        want = '0;
        for (int i = 0; i < CPU_COUNT; i++)
        begin
            if (online_wide[i] && (target_next[i] > want))
            begin
                want = target_next[i];
            end
        end

        if (evaluate && (want != running_next))
        begin
            applying_next = want;
            phase_next    = pfcs_pkg::PH_HOLD;
            timer_next    = hold_ticks_reg;
            started       = 1'b1;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                pfcs_pkg::CFG_HOLD_TICKS:   hold_ticks_next   = cfg_data;
                pfcs_pkg::CFG_SETTLE_TICKS: settle_ticks_next = cfg_data;
                pfcs_pkg::CFG_BOOT_INDEX:
                begin
                    boot_index_next = pfcs_pkg::sat_index(cfg_data[pfcs_pkg::INDEX_W-1:0]);
                    if (phase_reg == pfcs_pkg::PH_IDLE)
                    begin
                        running_next  = boot_index_next;
                        applying_next = boot_index_next;
                    end
                end
                pfcs_pkg::CFG_ONLINE_MASK:
                begin
                    online_mask_next = cfg_data[pfcs_pkg::MASK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        busy = (phase_next != pfcs_pkg::PH_IDLE);
        widx = busy ? applying_next : running_next;

        result.cpu_bypass    = busy;
        result.pll_bypass    = started;
        result.pll_reset     = (phase_next == pfcs_pkg::PH_HOLD);
        result.pll_ctl_word  = pfcs_pkg::ctl_word(widx);
        result.pll_ctl1_word = pfcs_pkg::ctl1_word(widx);
        result.pll_ctl1_word[pfcs_pkg::BYPASS_BIT] =
            result.pll_ctl1_word[pfcs_pkg::BYPASS_BIT] | started;
        result.current_index = running_next;
        result.current_khz   = pfcs_pkg::index_khz(running_next);
        result.busy_res      = busy;
        result.change_done   = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg   <= pfcs_pkg::HOLD_TICKS_RST;
            settle_ticks_reg <= pfcs_pkg::SETTLE_TICKS_RST;
            boot_index_reg   <= pfcs_pkg::BOOT_INDEX_RST;
            online_mask_reg  <= pfcs_pkg::ONLINE_MASK_RST;
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                target_reg[i] <= '0;
            end
            phase_reg    <= pfcs_pkg::PH_IDLE;
            timer_reg    <= '0;
            running_reg  <= pfcs_pkg::BOOT_INDEX_RST;
            applying_reg <= pfcs_pkg::BOOT_INDEX_RST;
        end
        else
        begin
            hold_ticks_reg   <= hold_ticks_next;
            settle_ticks_reg <= settle_ticks_next;
            boot_index_reg   <= boot_index_next;
            online_mask_reg  <= online_mask_next;
            target_reg       <= target_next;
            phase_reg        <= phase_next;
            timer_reg        <= timer_next;
            running_reg      <= running_next;
            applying_reg     <= applying_next;
        end
    end

    // A change start always comes with reset asserted and the CPU on bypass.
    a_start_sets_reset: assert property (@(posedge clk) disable iff (!rst_n)
        result.pll_bypass |-> (result.pll_reset && result.cpu_bypass))
        else $error("change start without PLL reset or CPU bypass");

    // Idle is only ever entered with the phase timer cleared.
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pfcs_pkg::PH_IDLE) |-> (timer_reg == '0))
        else $error("phase timer not clear while idle");

    // Requests during a change must not move the sequence on.
    a_request_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (item_cmd == pfcs_pkg::CMD_REQUEST) &&
         (phase_reg != pfcs_pkg::PH_IDLE))
        |=> ((phase_reg == $past(phase_reg)) && (timer_reg == $past(timer_reg))))
        else $error("request advanced the change sequence");

    // Running and applied indexes stay within the frequency table.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg <= pfcs_pkg::MAX_INDEX) && (applying_reg <= pfcs_pkg::MAX_INDEX))
        else $error("frequency index beyond table");

endmodule

[src/pfcs_out_buf.sv]
module pfcs_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pfcs_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output pfcs_pkg::result_t out_data
);

    pfcs_pkg::result_t entry_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic              wr_ptr;
    logic              pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr    = rd_ptr_reg ^ count_reg[0];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // The fill count never goes beyond the two entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // A held result with no pop keeps its data.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && (out_data == $past(out_data))))
        else $error("stalled result changed");

endmodule

[src/pll_frequency_change_sequencer.sv]
// PLL frequency change sequencer.
//
// Input channel s_*: one item per handshake. s_tuser[0] says whether the item is a
// time tick (0) or a frequency request (1); s_tdata carries the requesting CPU, the
// wanted frequency index and the PLL lock status sampled with the item.
// Output channel m_*: exactly one result item for every input item, in order, with
// the clock switch controls, both PLL control words, the running index and kHz,
// and the busy and change-done flags.
// Configuration channel cfg_*: register writes (hold ticks, settle ticks, boot
// index, online mask), always ready; they are meant to be issued while idle.
//
// The result of an item accepted at one edge is presented on m_tvalid after that
// edge. Throughput is one item per cycle while s_tready is high; the update of the
// per-CPU targets and the phase sequencer sits between the input handshake and a
// two-entry result buffer. When the receiver stalls, up to two results are held;
// s_tready drops only while both are occupied and rises as soon as one is taken.
// Reset clears the targets to index zero, puts the sequencer idle at the boot index,
// restores the register defaults and empties the result buffer.
module pll_frequency_change_sequencer #(
    parameter int CPU_COUNT = pfcs_pkg::CPU_COUNT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input item.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [0] cpu_id, [3:1] freq_index, [4] pll_locked, [7:5] zero.
    input  logic [7:0]                      s_tdata,
    // s_tuser: [0] cmd.
    input  logic [0:0]                      s_tuser,
    // Result item.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: [0] cpu_bypass, [1] pll_bypass, [2] pll_reset, [34:3] pll_ctl_word,
    // [66:35] pll_ctl1_word, [69:67] current_index, [90:70] current_khz,
    // [91] busy_res, [92] change_done, [95:93] zero.
    output logic [95:0]                     m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfcs_pkg::CFG_DATA_W-1:0] cfg_data
);

    pfcs_pkg::result_t core_result;
    pfcs_pkg::result_t buf_result;
    logic              accept;
    logic              buf_space;

    assign s_tready  = buf_space;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // The sequencer state advances on every accepted item and on register writes.
    pfcs_core #(
        .CPU_COUNT (CPU_COUNT)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_accept     (accept),
        .item_cmd        (s_tuser[0]),
        .item_cpu_id     (s_tdata[0]),
        .item_freq_index (s_tdata[3:1]),
        .item_pll_locked (s_tdata[4]),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result          (core_result)
    );

    // The result buffer decouples the two sides so a stalled receiver does not
    // stop intake until two results are waiting.
    pfcs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .space     (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_result)
    );

    assign m_tdata = {3'b000, buf_result};

endmodule

[dv/tb_pll_frequency_change_sequencer.sv]
module tb_pll_frequency_change_sequencer;

    timeunit 1ns;
    timeprecision 1ps;

    // Upper bound on the run, in clock cycles. About a thousand items are sent, and
    // even with sender gaps and the heaviest receiver stalls a correct run stays far
    // below this figure.
    localparam int unsigned LIMIT_CYCLES = 100_000;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int unsigned DRAIN_CYCLES = 4;
    // A register index that the block does not decode; writes to it must be ignored.
    localparam logic [pfcs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    // Number of random settings and the items sent under each of them.
    localparam int unsigned NUM_SETTINGS = 8;
    localparam int unsigned ITEMS_PER_SETTING = 100;
    // Ticks sent after a change has loaded the largest hold count.
    localparam int unsigned MAX_TIMER_TICKS = 40;

    // The scoreboard keeps its own copy of the sequencer state and predicts one
    // result per accepted item. Results are compared in order against that queue.
    class relock_tracker;
        localparam int NUM_CPUS = pfcs_pkg::CPU_COUNT_DEFAULT;
        localparam int MAX_REPORTS = 10;

        logic [pfcs_pkg::TICKS_W-1:0] hold_ticks;
        logic [pfcs_pkg::TICKS_W-1:0] settle_ticks;
        logic [pfcs_pkg::INDEX_W-1:0] boot_index;
        logic [pfcs_pkg::MASK_W-1:0]  online_mask;
        logic [pfcs_pkg::INDEX_W-1:0] cpu_target [NUM_CPUS];
        pfcs_pkg::phase_t             phase;
        logic [pfcs_pkg::TICKS_W-1:0] phase_timer;
        logic [pfcs_pkg::INDEX_W-1:0] running_index;
        logic [pfcs_pkg::INDEX_W-1:0] applying_index;
        pfcs_pkg::result_t            pending_results [$];
        int unsigned                  failures;

        function new();
            failures = 0;
            reset_state();
        endfunction

        function void reset_state();
            hold_ticks     = pfcs_pkg::HOLD_TICKS_RST;
            settle_ticks   = pfcs_pkg::SETTLE_TICKS_RST;
            boot_index     = pfcs_pkg::BOOT_INDEX_RST;
            online_mask    = pfcs_pkg::ONLINE_MASK_RST;
            foreach (cpu_target[i])
                cpu_target[i] = '0;
            phase          = pfcs_pkg::PH_IDLE;
            phase_timer    = '0;
            running_index  = boot_index;
            applying_index = boot_index;
            pending_results.delete();
        endfunction

        function logic [pfcs_pkg::INDEX_W-1:0] clip_index(logic [pfcs_pkg::INDEX_W-1:0] v);
            return (v > pfcs_pkg::MAX_INDEX) ? pfcs_pkg::MAX_INDEX : v;
        endfunction

        function logic [pfcs_pkg::WORD_W-1:0] pll_word0(logic [pfcs_pkg::INDEX_W-1:0] idx);
            case (idx)
                3'd2:    return 32'h9948B005;
                3'd4:    return 32'h9548A805;
                3'd5:    return 32'h9948B005;
                default: return 32'h8D48A005;
            endcase
        endfunction

        function logic [pfcs_pkg::WORD_W-1:0] pll_word1(logic [pfcs_pkg::INDEX_W-1:0] idx);
            case (idx)
                3'd0:    return 32'h0108342A;
                3'd1:    return 32'h010832AA;
                3'd2:    return 32'h010832AD;
                3'd3:    return 32'h0108312A;
                3'd4:    return 32'h0108312C;
                default: return 32'h0108312D;
            endcase
        endfunction

        // Highest wanted index among the online CPUs, zero when none is online.
        function logic [pfcs_pkg::INDEX_W-1:0] highest_target();
            logic [pfcs_pkg::INDEX_W-1:0] best;
            best = '0;
            for (int i = 0; i < NUM_CPUS; i++)
                if (online_mask[i] && cpu_target[i] > best)
                    best = cpu_target[i];
            return best;
        endfunction

        function bit start_change();
            logic [pfcs_pkg::INDEX_W-1:0] want;
            want = highest_target();
            if (want == running_index)
                return 1'b0;
            applying_index = want;
            phase          = pfcs_pkg::PH_HOLD;
            phase_timer    = hold_ticks;
            return 1'b1;
        endfunction

        function void write_register(logic [pfcs_pkg::CFG_IDX_W-1:0] idx,
                                     logic [pfcs_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pfcs_pkg::CFG_HOLD_TICKS:   hold_ticks = data;
                pfcs_pkg::CFG_SETTLE_TICKS: settle_ticks = data;
                pfcs_pkg::CFG_BOOT_INDEX:
                begin
                    boot_index = clip_index(data[pfcs_pkg::INDEX_W-1:0]);
                    if (phase == pfcs_pkg::PH_IDLE)
                    begin
                        running_index  = boot_index;
                        applying_index = boot_index;
                    end
                end
                pfcs_pkg::CFG_ONLINE_MASK:  online_mask = data[pfcs_pkg::MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_item(logic cmd, logic cpu,
                                  logic [pfcs_pkg::INDEX_W-1:0] fidx_raw, logic locked);
            logic [pfcs_pkg::INDEX_W-1:0] fidx;
            logic [pfcs_pkg::INDEX_W-1:0] widx;
            bit                           started;
            bit                           done;
            bit                           busy;
            pfcs_pkg::result_t            r;
            fidx    = clip_index(fidx_raw);
            started = 1'b0;
            done    = 1'b0;
            if (cmd == pfcs_pkg::CMD_REQUEST)
            begin
                if (int'(cpu) < NUM_CPUS)
                    cpu_target[cpu] = fidx;
                if (phase == pfcs_pkg::PH_IDLE)
                    started = start_change();
            end
            else
            begin
                case (phase)
                    pfcs_pkg::PH_HOLD:
                    begin
                        if (phase_timer == 0)
                        begin
                            phase       = pfcs_pkg::PH_SETTLE;
                            phase_timer = settle_ticks;
                        end
                        else
                            phase_timer = phase_timer - 1'b1;
                    end
                    pfcs_pkg::PH_SETTLE:
                    begin
                        if (phase_timer == 0)
                            phase = pfcs_pkg::PH_LOCK;
                        else
                            phase_timer = phase_timer - 1'b1;
                    end
                    pfcs_pkg::PH_LOCK:
                    begin
                        if (locked)
                        begin
                            running_index = applying_index;
                            phase         = pfcs_pkg::PH_IDLE;
                            phase_timer   = '0;
                            done          = 1'b1;
                            started       = start_change();
                        end
                    end
                    default: ;
                endcase
            end
            busy = (phase != pfcs_pkg::PH_IDLE);
            widx = busy ? applying_index : running_index;
            r.cpu_bypass    = busy;
            r.pll_bypass    = started;
            r.pll_reset     = (phase == pfcs_pkg::PH_HOLD);
            r.pll_ctl_word  = pll_word0(widx);
            r.pll_ctl1_word = pll_word1(widx)
                              | (started ? (32'd1 << pfcs_pkg::BYPASS_BIT) : 32'd0);
            r.current_index = running_index;
            r.current_khz   = pfcs_pkg::KHZ_W'(200000 * (int'(running_index) + 1));
            r.busy_res      = busy;
            r.change_done   = done;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                if (failures < MAX_REPORTS)
                    $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [95:0] word);
            pfcs_pkg::result_t got;
            pfcs_pkg::result_t want;
            got = word[$bits(pfcs_pkg::result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                    $display("result 0x%0h arrived with nothing expected", word);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("cpu_bypass", 32'(want.cpu_bypass), 32'(got.cpu_bypass));
            compare_field("pll_bypass", 32'(want.pll_bypass), 32'(got.pll_bypass));
            compare_field("pll_reset", 32'(want.pll_reset), 32'(got.pll_reset));
            compare_field("pll_ctl_word", want.pll_ctl_word, got.pll_ctl_word);
            compare_field("pll_ctl1_word", want.pll_ctl1_word, got.pll_ctl1_word);
            compare_field("current_index", 32'(want.current_index), 32'(got.current_index));
            compare_field("current_khz", 32'(want.current_khz), 32'(got.current_khz));
            compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
            compare_field("change_done", 32'(want.change_done), 32'(got.change_done));
        endfunction

        function void count_leftovers();
            if (pending_results.size() != 0)
            begin
                $display("%0d expected results never arrived", pending_results.size());
                failures += pending_results.size();
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [95:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pfcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pfcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    relock_tracker relock;

    // Sender pacing: bursts of random length separated by random gaps. When
    // pacing_on is clear, a new item is offered every cycle s_tready allows.
    bit          pacing_on = 1'b1;
    int unsigned burst_left = 0;

    // Receiver pattern state.
    bit [31:0]   rx_cycle = '0;
    int unsigned rx_stall = 0;

    pll_frequency_change_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offers one item and waits for it to be taken. The valid stays high after the
    // handshake unless a gap follows, so back-to-back items never lower and raise
    // it within the same time step.
    task automatic send_item(input logic cmd, input logic cpu,
                             input logic [pfcs_pkg::INDEX_W-1:0] fidx, input logic locked);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, locked, fidx, cpu};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        relock.accept_item(cmd, cpu, fidx, locked);
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(0, 20);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // A random item of either kind, with every field bit free to toggle.
    task automatic send_random_item(input int unsigned request_pct);
        logic cmd;
        cmd = ($urandom_range(0, 99) < request_pct) ? pfcs_pkg::CMD_REQUEST
                                                     : pfcs_pkg::CMD_TICK;
        send_item(cmd, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  $urandom_range(0, 2) != 0);
    endtask

    // Register write; the valid is left high so that several writes can follow one
    // another, and the caller lowers it once the batch is done.
    task automatic write_register(input logic [pfcs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pfcs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        relock.write_register(idx, data);
    endtask

    task automatic apply_setting(input logic [pfcs_pkg::CFG_DATA_W-1:0] hold,
                                 input logic [pfcs_pkg::CFG_DATA_W-1:0] settle,
                                 input logic [pfcs_pkg::CFG_DATA_W-1:0] boot,
                                 input logic [pfcs_pkg::CFG_DATA_W-1:0] mask);
        write_register(pfcs_pkg::CFG_HOLD_TICKS, hold);
        write_register(pfcs_pkg::CFG_SETTLE_TICKS, settle);
        write_register(pfcs_pkg::CFG_BOOT_INDEX, boot);
        write_register(pfcs_pkg::CFG_ONLINE_MASK, mask);
        cfg_valid <= 1'b0;
    endtask

    // Stops the sender and waits until every expected result has come back and the
    // drain margin has passed, so that the block is quiet before registers change.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (relock.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver checks every result taken and then decides its next ready. Its
    // pattern cycles through four modes: always ready, mostly ready, half ready and
    // stall bursts.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            relock.check_result(m_tdata);
        rx_cycle = rx_cycle + 1;
        case (rx_cycle[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 1) != 0);
            default:
            begin
                if (rx_stall != 0)
                begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        rx_stall = $urandom_range(1, 6);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog: a hung handshake or a sequencer that never finishes ends the run.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [pfcs_pkg::CFG_DATA_W-1:0] hold;
        logic [pfcs_pkg::CFG_DATA_W-1:0] settle;
        relock = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, first with the register defaults: ticks while idle, saturated
        // requests that match the boot index, and then requests that bring the highest
        // target down to zero and start a change.
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b1, 3'd7, 1'b1);
        send_item(pfcs_pkg::CMD_REQUEST, 1'b0, 3'd7, 1'b0);
        send_item(pfcs_pkg::CMD_REQUEST, 1'b1, 3'd6, 1'b1);
        send_item(pfcs_pkg::CMD_REQUEST, 1'b0, 3'd0, 1'b0);
        send_item(pfcs_pkg::CMD_REQUEST, 1'b1, 3'd0, 1'b0);
        // A request during the change only moves the target of CPU one.
        send_item(pfcs_pkg::CMD_REQUEST, 1'b1, 3'd3, 1'b1);
        // Lock reported during the hold phase must be ignored.
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b1);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        wait_drained();

        // The sequencer is now settling. A boot index written now is only stored,
        // and the new timer values wait for the next phase load.
        apply_setting(16'd0, 16'd0, 16'h0007, 16'h0003);
        while (relock.phase != pfcs_pkg::PH_LOCK)
            send_item(pfcs_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd5, 1'b0);
        // Lock completes the change to index zero; the higher target of CPU one
        // then starts the next change on the same item.
        send_item(pfcs_pkg::CMD_TICK, 1'b1, 3'd2, 1'b1);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b1);
        wait_drained();

        // With no CPU online the highest target counts as index zero.
        write_register(pfcs_pkg::CFG_ONLINE_MASK, 16'h0000);
        cfg_valid <= 1'b0;
        send_item(pfcs_pkg::CMD_REQUEST, 1'b0, 3'd4, 1'b0);
        while (relock.phase != pfcs_pkg::PH_IDLE)
            send_item(pfcs_pkg::CMD_TICK, 1'b1, 3'd1, 1'b1);
        wait_drained();

        // A boot index written while idle moves the running index, saturated.
        write_register(pfcs_pkg::CFG_BOOT_INDEX, 16'hFFF6);
        cfg_valid <= 1'b0;
        send_item(pfcs_pkg::CMD_REQUEST, 1'b1, 3'd2, 1'b0);
        send_item(pfcs_pkg::CMD_TICK, 1'b0, 3'd0, 1'b0);
        wait_drained();

        // Random part: several settings with short timers so that many changes run
        // to completion, each mask value at least twice, and junk in the unused
        // upper bits of the narrow registers.
        for (int unsigned s = 0; s < NUM_SETTINGS; s++)
        begin
            hold   = (s == 0) ? 16'd0 : 16'($urandom_range(0, 3));
            settle = (s == 0) ? 16'd0 : 16'($urandom_range(0, 3));
            write_register(CFG_UNUSED, 16'($urandom));
            apply_setting(hold, settle,
                          (16'($urandom) & 16'hFFF8) | 16'($urandom_range(0, 7)),
                          (16'($urandom) & 16'hFFFC) | 16'(s % 4));
            pacing_on = (s % 3 != 2);
            for (int unsigned n = 0; n < ITEMS_PER_SETTING; n++)
                send_random_item(35);
            wait_drained();
        end

        // Bring the sequencer to idle, so that the boot index write below takes hold.
        pacing_on = 1'b1;
        while (relock.phase != pfcs_pkg::PH_IDLE)
            send_item(pfcs_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), 1'b1);
        wait_drained();

        // Both timers at their maximum: a change from index zero to five loads the
        // full hold count, and a run of ticks counts it down from the top of its
        // range with lock reported all the way through and no sender gaps.
        apply_setting(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0003);
        pacing_on = 1'b0;
        send_item(pfcs_pkg::CMD_REQUEST, 1'b0, 3'd5, 1'b1);
        for (int unsigned n = 0; n < MAX_TIMER_TICKS; n++)
            send_item(pfcs_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), 1'b1);
        wait_drained();

        relock.count_leftovers();
        if (relock.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
src/pfcs_pkg.sv
src/pfcs_core.sv
src/pfcs_out_buf.sv
src/pll_frequency_change_sequencer.sv
dv/tb_pll_frequency_change_sequencer.sv
